// ===== hdl/xcfr_pkg.sv =====
// Package for the XOR-checked frame receiver.
// Holds the frame constants and the result type shared by the parser and the top level.
// Has no dependencies.
package xcfr_pkg;

	localparam logic [7:0] START_BYTE = 8'h96;
	localparam logic [7:0] SET_BIT    = 8'h01;

	typedef struct packed {
		logic        frame_ok;
		logic        is_set;
		logic [7:0]  command_byte;
		logic [7:0]  message_id;
		logic [31:0] payload_word;
	} result_t;

endpackage

// ===== hdl/xcfr_parser.sv =====
// Frame parser: hunts for the start byte, collects the frame fields and the running XOR.
// Produces the result for the checksum byte combinationally from the held frame state.
// Depends on xcfr_pkg.
module xcfr_parser #(
	parameter int PAYLOAD_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_take,
	input  logic [7:0]       byte_in,
	output logic             result_hit,
	output xcfr_pkg::result_t result
);
	import xcfr_pkg::*;

	localparam int PosW = $clog2(PAYLOAD_BYTES + 4);
	localparam logic [PosW-1:0] CheckPos = PosW'(3 + PAYLOAD_BYTES);
	localparam logic [PosW-1:0] CmdPos   = PosW'(1);
	localparam logic [PosW-1:0] IdPos    = PosW'(2);

	logic            in_frame_q;
	logic [PosW-1:0] pos_q;
	logic [7:0]      xor_q;
	logic [7:0]      command_q;
	logic [7:0]      id_q;
	logic [31:0]     payload_q;

	assign result_hit = in_frame_q && (pos_q >= CheckPos);

	always_comb begin
		result.frame_ok     = (xor_q == byte_in);
		result.is_set       = |(command_q & SET_BIT);
		result.command_byte = command_q;
		result.message_id   = id_q;
		result.payload_word = payload_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
		end else if (byte_take) begin
			if (!in_frame_q) begin
				if (byte_in == START_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= PosW'(1);
				end
			end else if (result_hit) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	// Frame fields are cleared at the start byte, so they need no reset.
	always_ff @(posedge clk) begin
		if (byte_take) begin
			if (!in_frame_q) begin
				if (byte_in == START_BYTE) begin
					xor_q     <= byte_in;
					command_q <= '0;
					id_q      <= '0;
					payload_q <= '0;
				end
			end else if (!result_hit) begin
				xor_q <= xor_q ^ byte_in;
				if (pos_q == CmdPos) begin
					command_q <= byte_in;
				end
				if (pos_q == IdPos) begin
					id_q <= byte_in;
				end
				// Payload bytes beyond the fourth only enter the XOR.
				for (int i = 0; i < 4; i++) begin
					if (pos_q == PosW'(3 + i) && i < PAYLOAD_BYTES) begin
						payload_q[i*8 +: 8] <= byte_in;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/xor_checked_frame_receiver.sv =====
// XOR-checked frame receiver: one byte per item in, one result item per complete frame out.
// Path: a checksum byte is held in the input register, and its result is registered in res_q.
// Throughput: one byte per cycle; the input register stalls only while a result is
// waiting to be taken and the byte in it is a checksum byte.
// Reset: arst_n clears the frame state to hunting and empties both registers.
// Depends on xcfr_pkg and xcfr_parser.
module xor_checked_frame_receiver #(
	parameter int PAYLOAD_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        frame_ok,
	output logic        is_set,
	output logic [7:0]  command_byte,
	output logic [7:0]  message_id,
	output logic [31:0] payload_word
);
	import xcfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_q;
	result_t    res_q;
	logic       out_free;
	logic       hit;
	logic       take_s1;
	result_t    parsed;

	xcfr_parser #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_take (take_s1),
		.byte_in   (byte_s1),
		.result_hit(hit),
		.result    (parsed)
	);

	assign out_free = !res_valid_q || !res_stall;
	// A byte that makes no result never waits on the output side.
	assign take_s1  = valid_s1 && (!hit || out_free);
	assign rx_stall = valid_s1 && !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= take_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && take_s1 && hit) begin
			res_q <= parsed;
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_ok     = res_q.frame_ok;
	assign is_set       = res_q.is_set;
	assign command_byte = res_q.command_byte;
	assign message_id   = res_q.message_id;
	assign payload_word = res_q.payload_word;

endmodule

// ===== hdl/xcfr_checker.sv =====
// Port-level checker for the XOR-checked frame receiver, bound to the top level.
// Sees only the top level's ports; depends on no package.
module xcfr_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic        frame_ok,
	input logic        is_set,
	input logic [7:0]  command_byte,
	input logic [7:0]  message_id,
	input logic [31:0] payload_word
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(command_byte)
			&& $stable(message_id) && $stable(payload_word) && $stable(frame_ok))
		else $error("result item changed while stalled");

	a_set_bit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> is_set == command_byte[0])
		else $error("is_set does not match command bit 0");

	// Input is held back only by a result that is waiting to be taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall)
		else $error("input stalled without a blocked result");

	// A fresh result traces back to a byte accepted through the input register.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && !rx_stall, 2))
		else $error("result appeared without a checksum byte");

endmodule

bind xor_checked_frame_receiver xcfr_port_checker u_xcfr_checker (.*);
